### src/axis_homing_and_move_sequencer_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the axis homing and move sequencer
// Clocked implication checks, reset-qualified, reporting through $error.
// ---------------------------------------------------------------------------
`ifndef AXIS_HOMING_AND_MOVE_SEQUENCER_CORE_MACROS_SVH
`define AXIS_HOMING_AND_MOVE_SEQUENCER_CORE_MACROS_SVH

// same-cycle implication
`define AHMS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define AHMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/ahms_pkg.sv
// ---------------------------------------------------------------------------
// ahms_pkg
// Types, codes and the microcode table of the axis homing and move sequencer.
// ---------------------------------------------------------------------------
package ahms_pkg;

   // field widths
   localparam int OP_W     = 3;
   localparam int UNIT_W   = 12;
   localparam int SPU_W    = 8;
   localparam int SPEED_W  = 16;
   localparam int SETTLE_W = 16;
   localparam int SPOS_W   = 24;
   localparam int VAL_W    = 24;
   localparam int POS_W    = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 56;
   localparam int DIV_CNT_W = 5;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OPEN_TARGET     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OPEN_TARGET_ALT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEPS_PER_UNIT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_SPEED    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_TICKS    = 3'd4;

   // configuration reset values
   localparam logic [UNIT_W-1:0]   RST_OPEN_TARGET     = 12'd280;
   localparam logic [UNIT_W-1:0]   RST_OPEN_TARGET_ALT = 12'd300;
   localparam logic [SPU_W-1:0]    RST_STEPS_PER_UNIT  = 8'd80;
   localparam logic [SPEED_W-1:0]  RST_SEARCH_SPEED    = 16'd400;
   localparam logic [SETTLE_W-1:0] RST_SETTLE_TICKS    = 16'd100;

   typedef enum logic [OP_W-1:0] {
      OP_TICK     = 3'd0,
      OP_HOME     = 3'd1,
      OP_MOVE     = 3'd2,
      OP_OPEN     = 3'd3,
      OP_OPEN_ALT = 3'd4,
      OP_CLOSE    = 3'd5,
      OP_STOP     = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      AX_UNKNOWN = 3'd0,
      AX_READY   = 3'd1,
      AX_HOMING  = 3'd2,
      AX_MOVING  = 3'd3,
      AX_ERROR   = 3'd4
   } axis_type;

   typedef enum logic [1:0] {
      DOOR_CLOSED  = 2'd0,
      DOOR_OPEN    = 2'd1,
      DOOR_OPENING = 2'd2,
      DOOR_CLOSING = 2'd3
   } door_type;

   typedef enum logic [2:0] {
      CMD_NONE = 3'd0,
      CMD_CW   = 3'd1,
      CMD_CCW  = 3'd2,
      CMD_STOP = 3'd3,
      CMD_MOVE = 3'd4,
      CMD_ZERO = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      HS_START    = 3'd0,
      HS_APPROACH = 3'd1,
      HS_SETTLE1  = 3'd2,
      HS_BACKOFF  = 3'd3,
      HS_SETTLE2  = 3'd4,
      HS_FINAL    = 3'd5
   } hstep_type;

   // microcode
   typedef logic [2:0] upc_type;

   typedef enum logic [2:0] {
      ACT_IDLE,      // take a request beat
      ACT_DECODE,    // look at the latched beat
      ACT_DIV_START, // launch the position divide
      ACT_DIV_WAIT,  // wait for the divider
      ACT_EXEC,      // commit state and load the response
      ACT_HOLD       // response slot still full
   } act_type;

   typedef enum logic [2:0] {
      J_NEVER,
      J_ALWAYS,
      J_NO_BEAT,
      J_NO_DIV,
      J_DIV_BUSY,
      J_OUT_FREE
   } jcond_type;

   typedef struct packed {
      act_type   act;
      jcond_type jcond;
      upc_type   jaddr;
   } ctrl_word_type;

   typedef struct packed {
      logic beat;
      logic need_div;
      logic div_busy;
      logic out_free;
   } useq_cond_type;

   function automatic ctrl_word_type ucode_rom(input upc_type pc);
      ctrl_word_type w;
      case (pc)
         3'd0:    w = '{act: ACT_IDLE,      jcond: J_NO_BEAT,  jaddr: 3'd0};
         3'd1:    w = '{act: ACT_DECODE,    jcond: J_NO_DIV,   jaddr: 3'd4};
         3'd2:    w = '{act: ACT_DIV_START, jcond: J_NEVER,    jaddr: 3'd0};
         3'd3:    w = '{act: ACT_DIV_WAIT,  jcond: J_DIV_BUSY, jaddr: 3'd3};
         3'd4:    w = '{act: ACT_EXEC,      jcond: J_OUT_FREE, jaddr: 3'd0};
         3'd5:    w = '{act: ACT_HOLD,      jcond: J_ALWAYS,   jaddr: 3'd4};
         default: w = '{act: ACT_HOLD,      jcond: J_ALWAYS,   jaddr: 3'd0};
      endcase
      return w;
   endfunction

endpackage

### src/ahms_div.sv
// ---------------------------------------------------------------------------
// ahms_div
// Serial restoring divider, one quotient bit per cycle, unsigned operands.
// ---------------------------------------------------------------------------
module ahms_div
   import ahms_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SPOS_W-1:0] dividend,
   input  logic [SPU_W-1:0]  divisor,   // nonzero
   output logic              busy,
   output logic [SPOS_W-1:0] quotient
);

   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SPOS_W-1:0]    quo_ff, quo_in;
   logic [SPU_W-1:0]     rem_ff, rem_in;
   logic [SPU_W-1:0]     dvs_ff, dvs_in;
   logic [SPU_W:0]       trial;
   logic                 fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[SPOS_W-1]};
      fits   = (trial >= {1'b0, dvs_ff});
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (start) begin
         cnt_in = DIV_CNT_W'(SPOS_W);
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         quo_in = {quo_ff[SPOS_W-2:0], fits};
         rem_in = fits ? SPU_W'(trial - {1'b0, dvs_ff}) : trial[SPU_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = quo_ff;

endmodule

### src/ahms_useq.sv
// ---------------------------------------------------------------------------
// ahms_useq
// Microprogram counter and control store with conditional jumps.
// ---------------------------------------------------------------------------
module ahms_useq
   import ahms_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  useq_cond_type cond,
   output ctrl_word_type ctrl
);

   upc_type upc_ff, upc_in;
   logic    take;

   always_comb begin
      ctrl = ucode_rom(upc_ff);
      case (ctrl.jcond)
         J_NEVER:    take = 1'b0;
         J_ALWAYS:   take = 1'b1;
         J_NO_BEAT:  take = !cond.beat;
         J_NO_DIV:   take = !cond.need_div;
         J_DIV_BUSY: take = cond.div_busy;
         J_OUT_FREE: take = cond.out_free;
         default:    take = 1'b1;
      endcase
      upc_in = take ? ctrl.jaddr : upc_type'(upc_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= '0;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

### src/axis_homing_and_move_sequencer_core.sv
// ---------------------------------------------------------------------------
// axis_homing_and_move_sequencer_core
// Homing and move sequencer for one stepper axis with an origin switch.
// ---------------------------------------------------------------------------
// Sequence: each request beat is taken, decoded and executed, execute
// loading the response register; a tick that completes a move starts
// the serial divider after decode and waits for it before execute. The
// next beat is taken while the previous response waits on rsp_tready,
// and a full response slot holds execute.
// Reset: synchronous; config back to defaults, axis unknown, door closed.
// ---------------------------------------------------------------------------
module axis_homing_and_move_sequencer_core
   import ahms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request beats
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // target_position[11:0], origin_sensor[12],
                                             // stepper_ready[13], stepper_position[37:14]
   input  logic [OP_W-1:0]       req_tuser,  // operation[2:0]
   // response beats
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // busy_refused[0], command_value[24:1],
                                             // axis_state_out[27:25], door_state_out[29:28],
                                             // position_out[45:30], is_open[46],
                                             // is_closed[47], is_busy[48]
   output logic [2:0]            rsp_tuser,  // motor_command[2:0]
   // configuration writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

`include "axis_homing_and_move_sequencer_core_macros.svh"

   // ---------------- configuration registers ----------------
   logic [UNIT_W-1:0]   open_target_ff;
   logic [UNIT_W-1:0]   open_target_alt_ff;
   logic [SPU_W-1:0]    steps_per_unit_ff;
   logic [SPEED_W-1:0]  search_speed_ff;
   logic [SETTLE_W-1:0] settle_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_target_ff     <= RST_OPEN_TARGET;
         open_target_alt_ff <= RST_OPEN_TARGET_ALT;
         steps_per_unit_ff  <= RST_STEPS_PER_UNIT;
         search_speed_ff    <= RST_SEARCH_SPEED;
         settle_ticks_ff    <= RST_SETTLE_TICKS;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OPEN_TARGET:     open_target_ff     <= csr_wdata[UNIT_W-1:0];
            CSR_OPEN_TARGET_ALT: open_target_alt_ff <= csr_wdata[UNIT_W-1:0];
            CSR_STEPS_PER_UNIT:  steps_per_unit_ff  <= csr_wdata[SPU_W-1:0];
            CSR_SEARCH_SPEED:    search_speed_ff    <= csr_wdata[SPEED_W-1:0];
            CSR_SETTLE_TICKS:    settle_ticks_ff    <= csr_wdata[SETTLE_W-1:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // ---------------- microcode sequencer ----------------
   ctrl_word_type ctrl;
   useq_cond_type cond;
   logic          beat;
   logic          commit;
   logic          div_busy;
   logic [SPOS_W-1:0] div_quo;

   // no beat is taken while reset is held
   assign req_tready = (ctrl.act == ACT_IDLE) && !reset;
   assign beat       = req_tvalid && req_tready;

   ahms_useq u_useq (
      .clock (clock),
      .reset (reset),
      .cond  (cond),
      .ctrl  (ctrl)
   );

   // ---------------- latched request beat ----------------
   op_type              op_ff;
   logic [UNIT_W-1:0]   target_ff;
   logic                sensor_ff;
   logic                drv_ready_ff;
   logic [SPOS_W-1:0]   spos_ff;

   always_ff @(posedge clock) begin
      if (beat) begin
         op_ff        <= op_type'(req_tuser);
         target_ff    <= req_tdata[11:0];
         sensor_ff    <= req_tdata[12];
         drv_ready_ff <= req_tdata[13];
         spos_ff      <= req_tdata[37:14];
      end
   end

   // ---------------- axis state ----------------
   axis_type            axis_state_ff, axis_state_in;
   hstep_type           hstep_ff, hstep_in;
   logic [POS_W-1:0]    axis_pos_ff, axis_pos_in;
   door_type            door_ff, door_in;
   logic [SETTLE_W-1:0] settle_ff, settle_in;

   logic axis_busy;
   assign axis_busy = (axis_state_ff == AX_HOMING) || (axis_state_ff == AX_MOVING);

   // a tick that finds the driver ready ends a move and needs the divide
   logic need_div;
   assign need_div = (op_ff == OP_TICK) && (axis_state_ff == AX_MOVING) && drv_ready_ff;

   // response slot free: empty, or being drained this edge
   logic out_free;
   assign out_free = !rsp_tvalid || rsp_tready;

   assign cond.beat     = beat;
   assign cond.need_div = need_div;
   assign cond.div_busy = div_busy;
   assign cond.out_free = out_free;

   assign commit = (ctrl.act == ACT_EXEC) && out_free;

   // ---------------- position divide ----------------
   // magnitude of the driver position over steps per unit (zero taken as one)
   logic              spos_neg;
   logic [SPOS_W-1:0] spos_mag;
   logic [SPU_W-1:0]  divisor;

   assign spos_neg = spos_ff[SPOS_W-1];
   assign spos_mag = spos_neg ? SPOS_W'(-spos_ff) : spos_ff;
   assign divisor  = (steps_per_unit_ff == '0) ? SPU_W'(1) : steps_per_unit_ff;

   ahms_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.act == ACT_DIV_START),
      .dividend (spos_mag),
      .divisor  (divisor),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // truncated quotient, signed and saturated to 16 bits
   logic [POS_W-1:0] q_sat;
   always_comb begin
      if (!spos_neg) begin
         q_sat = (div_quo > SPOS_W'(32767)) ? 16'h7FFF : div_quo[POS_W-1:0];
      end else begin
         q_sat = (div_quo > SPOS_W'(32768)) ? 16'h8000 : POS_W'(-div_quo[POS_W-1:0]);
      end
   end

   // ---------------- execute: next state and response ----------------
   logic [UNIT_W-1:0]       move_units;
   logic [UNIT_W+SPU_W-1:0] move_pulses;
   logic [SETTLE_W-1:0]     settle_dec;
   logic                    refused_c;
   cmd_type                 cmd_c;
   logic [VAL_W-1:0]        val_c;
   logic [VAL_W-1:0]        speed_val;
   logic                    is_open_c;
   logic                    is_closed_c;
   logic                    is_busy_c;

   always_comb begin
      case (op_ff)
         OP_MOVE:     move_units = target_ff;
         OP_OPEN:     move_units = open_target_ff;
         OP_OPEN_ALT: move_units = open_target_alt_ff;
         default:     move_units = '0;  // close goes to zero
      endcase
   end

   assign move_pulses = move_units * steps_per_unit_ff;
   assign speed_val   = VAL_W'(search_speed_ff);
   assign settle_dec  = (settle_ff != '0) ? SETTLE_W'(settle_ff - 1'b1) : '0;

   always_comb begin
      axis_state_in = axis_state_ff;
      hstep_in      = hstep_ff;
      axis_pos_in   = axis_pos_ff;
      door_in       = door_ff;
      settle_in     = settle_ff;
      cmd_c         = CMD_NONE;
      val_c         = '0;
      refused_c     = 1'b0;

      case (op_ff)
         OP_TICK: begin
            if (axis_state_ff == AX_HOMING) begin
               case (hstep_ff)
                  HS_APPROACH: begin
                     if (sensor_ff) begin
                        cmd_c     = CMD_STOP;
                        settle_in = settle_ticks_ff;
                        hstep_in  = HS_SETTLE1;
                     end
                  end
                  HS_SETTLE1: begin
                     // count drops every tick; pause ends once it hits zero
                     settle_in = settle_dec;
                     if (settle_dec == '0) begin
                        cmd_c    = CMD_CW;
                        val_c    = speed_val;
                        hstep_in = HS_BACKOFF;
                     end
                  end
                  HS_BACKOFF: begin
                     if (!sensor_ff) begin
                        cmd_c     = CMD_STOP;
                        settle_in = settle_ticks_ff;
                        hstep_in  = HS_SETTLE2;
                     end
                  end
                  HS_SETTLE2: begin
                     settle_in = settle_dec;
                     if (settle_dec == '0) begin
                        cmd_c    = CMD_CCW;
                        val_c    = speed_val;
                        hstep_in = HS_FINAL;
                     end
                  end
                  HS_FINAL: begin
                     if (sensor_ff) begin
                        cmd_c         = CMD_ZERO;
                        hstep_in      = HS_START;
                        axis_pos_in   = '0;
                        axis_state_in = AX_READY;
                     end
                  end
                  default: begin
                     // start: back off the switch if on it, else approach it
                     cmd_c    = sensor_ff ? CMD_CW : CMD_CCW;
                     val_c    = speed_val;
                     hstep_in = sensor_ff ? HS_BACKOFF : HS_APPROACH;
                  end
               endcase
            end else if (need_div) begin
               axis_pos_in   = q_sat;
               axis_state_in = AX_READY;
               if (door_ff == DOOR_OPENING) begin
                  door_in = DOOR_OPEN;
               end else if (door_ff == DOOR_CLOSING) begin
                  door_in = DOOR_CLOSED;
               end
            end
         end
         OP_HOME: begin
            if (axis_busy) begin
               refused_c = 1'b1;
            end else begin
               axis_state_in = AX_HOMING;
               hstep_in      = HS_START;
            end
         end
         OP_MOVE, OP_OPEN, OP_OPEN_ALT, OP_CLOSE: begin
            // door status follows open/close even when the move is refused
            if ((op_ff == OP_OPEN) || (op_ff == OP_OPEN_ALT)) begin
               door_in = DOOR_OPENING;
            end else if (op_ff == OP_CLOSE) begin
               door_in = DOOR_CLOSING;
            end
            if (axis_busy) begin
               refused_c = 1'b1;
            end else begin
               axis_state_in = AX_MOVING;
               cmd_c         = CMD_MOVE;
               val_c         = VAL_W'(move_pulses);
            end
         end
         OP_STOP: begin
            cmd_c = CMD_STOP;
         end
         default: ;  // unused code: no effect
      endcase
   end

   // query flags reflect the state after this beat
   assign is_open_c   = (axis_state_in == AX_READY) &&
                        (axis_pos_in == {{(POS_W-UNIT_W){1'b0}}, open_target_ff});
   assign is_closed_c = (axis_state_in == AX_READY) && (axis_pos_in == '0);
   assign is_busy_c   = (axis_state_in == AX_HOMING) || (axis_state_in == AX_MOVING);

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_state_ff <= AX_UNKNOWN;
         hstep_ff      <= HS_START;
         axis_pos_ff   <= '0;
         door_ff       <= DOOR_CLOSED;
         settle_ff     <= '0;
      end else if (commit) begin
         axis_state_ff <= axis_state_in;
         hstep_ff      <= hstep_in;
         axis_pos_ff   <= axis_pos_in;
         door_ff       <= door_in;
         settle_ff     <= settle_in;
      end
   end

   // ---------------- response register ----------------
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   cmd_type               rsp_cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_cmd_ff  <= cmd_c;
         rsp_data_ff <= {7'd0, is_busy_c, is_closed_c, is_open_c, axis_pos_in,
                         door_in, axis_state_in, val_c, refused_c};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_cmd_ff;

   // ---------------- assertions ----------------
   `AHMS_ASSERT_NOW(a_div_start_idle, clock, reset, ctrl.act == ACT_DIV_START, !div_busy, "divider restarted while busy")
   `AHMS_ASSERT_NEXT(a_commit_loads_rsp, clock, reset, commit, rsp_tvalid, "committed beat produced no response")
   `AHMS_ASSERT_NOW(a_hstep_only_homing, clock, reset, hstep_ff != HS_START, axis_state_ff == AX_HOMING, "homing step active outside homing")
   `AHMS_ASSERT_NEXT(a_refused_no_cmd, clock, reset, commit && refused_c, rsp_tuser == CMD_NONE, "refused request issued a motor command")

endmodule

### test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: homing and move sequencer testbench
// Drives request beats with random gaps and stalls the response side at
// random. Every accepted beat runs through an in-bench model of the axis,
// and each response beat is compared field by field with the oldest
// prediction. Registers change only between phases, once the block is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import ahms_pkg::*;

   // opcode with no function; the block must leave its state alone
   localparam logic [OP_W-1:0]      OP_UNUSED   = 3'd7;
   // register index outside the map; writes to it are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED  = 3'd7;
   // idle tail that quiesce waits out after the last response; leave margin
   localparam int                   TAIL_CYCLES = 40;
   // sized for a worst case of about 1100 beats
   localparam longint               RUN_LIMIT_NS = 64'd20_000_000;

   // one response beat as the bench expects it; vectors hold raw bit patterns
   typedef struct packed {
      logic                refused;
      cmd_type             command;
      logic [VAL_W-1:0]    value;
      axis_type            axis;
      door_type            door;
      logic [POS_W-1:0]    position;
      logic                open_flag;
      logic                closed_flag;
      logic                busy_flag;
   } motion_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // target_position, origin_sensor,
                                           // stepper_ready, stepper_position
   logic [OP_W-1:0]       req_tuser = '0;  // operation
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // busy_refused, command_value,
                                           // axis_state_out, door_state_out,
                                           // position_out, is_open, is_closed,
                                           // is_busy
   logic [2:0]            rsp_tuser;       // motor_command
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   axis_homing_and_move_sequencer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Axis model: register copies and sequencer state
   // ------------------------------------------------------------------
   logic [UNIT_W-1:0]   cfg_open;
   logic [UNIT_W-1:0]   cfg_open_alt;
   logic [SPU_W-1:0]    cfg_spu;
   logic [SPEED_W-1:0]  cfg_speed;
   logic [SETTLE_W-1:0] cfg_settle;

   axis_type            axis_now;
   hstep_type           home_step;
   int                  position;
   door_type            door_now;
   logic [SETTLE_W-1:0] settle_left;

   motion_result_type   pending_results[$];
   int                  error_count;
   int                  beats_sent;
   bit                  quiet_mode;  // no gaps and no stalls while set
   int                  stall_left;

   function automatic bit axis_busy();
      return axis_now == AX_HOMING || axis_now == AX_MOVING;
   endfunction

   // count down, then report whether the pause is over
   function automatic bit settle_elapsed();
      if (settle_left != 0)
         settle_left = settle_left - 1'b1;
      return settle_left == 0;
   endfunction

   function automatic void home_tick(input logic sensor, inout motion_result_type r);
      case (home_step)
         HS_APPROACH: begin
            if (sensor) begin
               r.command   = CMD_STOP;
               settle_left = cfg_settle;
               home_step   = HS_SETTLE1;
            end
         end
         HS_SETTLE1: begin
            if (settle_elapsed()) begin
               r.command = CMD_CW;
               r.value   = {8'h00, cfg_speed};
               home_step = HS_BACKOFF;
            end
         end
         HS_BACKOFF: begin
            if (!sensor) begin
               r.command   = CMD_STOP;
               settle_left = cfg_settle;
               home_step   = HS_SETTLE2;
            end
         end
         HS_SETTLE2: begin
            if (settle_elapsed()) begin
               r.command = CMD_CCW;
               r.value   = {8'h00, cfg_speed};
               home_step = HS_FINAL;
            end
         end
         HS_FINAL: begin
            if (sensor) begin
               r.command = CMD_ZERO;
               home_step = HS_START;
               position  = 0;
               axis_now  = AX_READY;
            end
         end
         default: begin
            // start: back off first when already on the switch
            r.command = sensor ? CMD_CW : CMD_CCW;
            r.value   = {8'h00, cfg_speed};
            home_step = sensor ? HS_BACKOFF : HS_APPROACH;
         end
      endcase
   endfunction

   function automatic bit begin_move(input logic [UNIT_W-1:0] units,
                                     inout motion_result_type r);
      logic [31:0] pulses;
      if (axis_busy())
         return 1'b0;
      axis_now  = AX_MOVING;
      r.command = CMD_MOVE;
      // multiplier is the raw register, even when it is zero
      pulses    = units * cfg_spu;
      r.value   = pulses[VAL_W-1:0];
      return 1'b1;
   endfunction

   function automatic motion_result_type step_axis(input logic [OP_W-1:0]   op,
                                                   input logic [UNIT_W-1:0] target,
                                                   input logic              sensor,
                                                   input logic              ready,
                                                   input logic [SPOS_W-1:0] spos);
      motion_result_type r;
      int                divisor;
      int                q;
      r         = '0;
      r.command = CMD_NONE;
      case (op)
         OP_TICK: begin
            if (axis_now == AX_HOMING) begin
               home_tick(sensor, r);
            end else if (axis_now == AX_MOVING && ready) begin
               // divide truncates toward zero; a zero divisor acts as one
               divisor = (cfg_spu == 0) ? 1 : int'(cfg_spu);
               q       = int'($signed(spos)) / divisor;
               if (q > 32767)
                  q = 32767;
               if (q < -32768)
                  q = -32768;
               position = q;
               axis_now = AX_READY;
               if (door_now == DOOR_OPENING)
                  door_now = DOOR_OPEN;
               else if (door_now == DOOR_CLOSING)
                  door_now = DOOR_CLOSED;
            end
         end
         OP_HOME: begin
            if (axis_busy()) begin
               r.refused = 1'b1;
            end else begin
               axis_now  = AX_HOMING;
               home_step = HS_START;
            end
         end
         OP_MOVE: r.refused = !begin_move(target, r);
         // door status moves even if the move is then refused
         OP_OPEN: begin
            door_now  = DOOR_OPENING;
            r.refused = !begin_move(cfg_open, r);
         end
         OP_OPEN_ALT: begin
            door_now  = DOOR_OPENING;
            r.refused = !begin_move(cfg_open_alt, r);
         end
         OP_CLOSE: begin
            door_now  = DOOR_CLOSING;
            r.refused = !begin_move('0, r);
         end
         OP_STOP: r.command = CMD_STOP;
         default: ;
      endcase
      r.axis        = axis_now;
      r.door        = door_now;
      r.position    = position[POS_W-1:0];
      r.open_flag   = axis_now == AX_READY && position == int'(cfg_open);
      r.closed_flag = axis_now == AX_READY && position == 0;
      r.busy_flag   = axis_busy();
      return r;
   endfunction

   function automatic void store_reg(input logic [CSR_IDX_W-1:0]  idx,
                                     input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_OPEN_TARGET:     cfg_open     = data[UNIT_W-1:0];
         CSR_OPEN_TARGET_ALT: cfg_open_alt = data[UNIT_W-1:0];
         CSR_STEPS_PER_UNIT:  cfg_spu      = data[SPU_W-1:0];
         CSR_SEARCH_SPEED:    cfg_speed    = data[SPEED_W-1:0];
         CSR_SETTLE_TICKS:    cfg_settle   = data[SETTLE_W-1:0];
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Mismatch reporting and the response checker
   // ------------------------------------------------------------------
   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         flag_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin
      motion_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            flag_mismatch("response beat with nothing pending", rsp_tdata[31:0], '0);
         end else begin
            want = pending_results.pop_front();
            check_field("busy_refused",   rsp_tdata[0],     want.refused);
            check_field("motor_command",  rsp_tuser,        want.command);
            check_field("command_value",  rsp_tdata[24:1],  want.value);
            check_field("axis_state_out", rsp_tdata[27:25], want.axis);
            check_field("door_state_out", rsp_tdata[29:28], want.door);
            check_field("position_out",   rsp_tdata[45:30], want.position);
            check_field("is_open",        rsp_tdata[46],    want.open_flag);
            check_field("is_closed",      rsp_tdata[47],    want.closed_flag);
            check_field("is_busy",        rsp_tdata[48],    want.busy_flag);
         end
      end
   end

   // ------------------------------------------------------------------
   // Idling on both sides
   // ------------------------------------------------------------------
   // mostly short pauses, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // response side: random stall runs, none while quiet
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 99) < 25) begin
         stall_left <= pick_gap() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic sender_gap();
      int n;
      n = (quiet_mode || $urandom_range(0, 99) < 60) ? 0 : pick_gap();
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // ------------------------------------------------------------------
   // Beat driver; valid stays high across back-to-back beats
   // ------------------------------------------------------------------
   task automatic send_beat(input logic [OP_W-1:0]   op,
                            input logic [UNIT_W-1:0] target,
                            input logic              sensor,
                            input logic              ready,
                            input logic [SPOS_W-1:0] spos);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, spos, ready, sensor, target};
      do
         @(posedge clock);
      while (!req_tready);
      pending_results.push_back(step_axis(op, target, sensor, ready, spos));
      beats_sent++;
      sender_gap();
   endtask

   // hold off until every pending response has been seen
   task automatic wait_all_results();
      if (pending_results.size() != 0) begin
         req_tvalid <= 1'b0;
         while (pending_results.size() != 0)
            @(posedge clock);
      end
   endtask

   // idle the block fully: wait for every pending response, then hold valid low
   task automatic quiesce();
      wait_all_results();
      req_tvalid <= 1'b0;
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [CSR_DATA_W-1:0] open_t,
                                 input logic [CSR_DATA_W-1:0] alt_t,
                                 input logic [CSR_DATA_W-1:0] spu,
                                 input logic [CSR_DATA_W-1:0] speed,
                                 input logic [CSR_DATA_W-1:0] settle,
                                 input bit                    poke_unused);
      logic [CSR_IDX_W-1:0]  idx [6];
      logic [CSR_DATA_W-1:0] val [6];
      int                    n;
      idx = '{CSR_OPEN_TARGET, CSR_OPEN_TARGET_ALT, CSR_STEPS_PER_UNIT,
              CSR_SEARCH_SPEED, CSR_SETTLE_TICKS, CSR_UNUSED};
      val = '{open_t, alt_t, spu, speed, settle, 16'hFFFF};
      n   = poke_unused ? 6 : 5;
      quiesce();
      // write enable stays up across the burst, drops once at the end
      for (int i = 0; i < n; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         store_reg(idx[i], val[i]);
      end
      csr_we <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Random traffic: homing runs, move runs and noise
   // ------------------------------------------------------------------
   function automatic logic [SPOS_W-1:0] to_spos(input int pulses);
      return pulses[SPOS_W-1:0];
   endfunction

   task automatic noise_beat();
      send_beat(OP_W'($urandom_range(0, 7)), UNIT_W'($urandom), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), SPOS_W'($urandom));
   endtask

   // ticks that mostly move the homing sequence along
   task automatic homing_ticks();
      logic advance;
      for (int i = 0; i < 12 && axis_now == AX_HOMING; i++) begin
         case (home_step)
            HS_APPROACH, HS_FINAL: advance = 1'b1;
            HS_BACKOFF:            advance = 1'b0;
            default:               advance = 1'($urandom_range(0, 1));
         endcase
         if ($urandom_range(0, 99) < 8)
            send_beat(OP_W'($urandom_range(OP_HOME, OP_STOP)), UNIT_W'($urandom),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), SPOS_W'($urandom));
         else
            send_beat(OP_TICK, UNIT_W'($urandom),
                      ($urandom_range(0, 99) < 60) ? advance : !advance,
                      1'($urandom_range(0, 1)), SPOS_W'($urandom));
      end
   endtask

   task automatic move_sequence();
      logic [OP_W-1:0]   op;
      logic [UNIT_W-1:0] target;
      logic [UNIT_W-1:0] units;
      int                pulses;
      int                jitter;
      int                mode;
      case ($urandom_range(0, 3))
         0:       op = OP_MOVE;
         1:       op = OP_OPEN;
         2:       op = OP_OPEN_ALT;
         default: op = OP_CLOSE;
      endcase
      mode   = $urandom_range(0, 9);
      target = (mode < 2) ? '0 : (mode < 4) ? '1 : UNIT_W'($urandom);
      units  = (op == OP_MOVE) ? target : (op == OP_OPEN) ? cfg_open :
               (op == OP_OPEN_ALT) ? cfg_open_alt : '0;
      send_beat(op, target, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                SPOS_W'($urandom));
      if (axis_now != AX_MOVING)
         return;
      repeat ($urandom_range(0, 3)) begin
         if ($urandom_range(0, 99) < 15)
            send_beat(OP_W'($urandom_range(OP_HOME, OP_CLOSE)), UNIT_W'($urandom),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), SPOS_W'($urandom));
         else
            send_beat(OP_TICK, UNIT_W'($urandom), 1'($urandom_range(0, 1)), 1'b0,
                      SPOS_W'($urandom));
      end
      // completion: near the commanded pulses, mirrored, or anywhere
      pulses = int'(units) * int'(cfg_spu);
      jitter = $urandom_range(0, (cfg_spu == 0) ? 0 : cfg_spu - 1);
      mode   = $urandom_range(0, 9);
      if (mode < 6)
         send_beat(OP_TICK, UNIT_W'($urandom), 1'($urandom_range(0, 1)), 1'b1,
                   to_spos(pulses + jitter));
      else if (mode < 8)
         send_beat(OP_TICK, UNIT_W'($urandom), 1'($urandom_range(0, 1)), 1'b1,
                   to_spos(-pulses - jitter));
      else
         send_beat(OP_TICK, UNIT_W'($urandom), 1'($urandom_range(0, 1)), 1'b1,
                   SPOS_W'($urandom));
   endtask

   task automatic run_traffic(input int count);
      int done_at;
      int pick;
      done_at = beats_sent + count;
      while (beats_sent < done_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 3)
            wait_all_results();
         if (axis_now == AX_HOMING)
            homing_ticks();
         else if (pick < 30)
            send_beat(OP_HOME, UNIT_W'($urandom), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), SPOS_W'($urandom));
         else if (pick < 80)
            move_sequence();
         else
            noise_beat();
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // defaults after reset: stop, unused op, moves from unknown, refusals,
   // saturated positions and door completion, then homing off the switch
   task automatic test_reset_state_and_moves();
      send_beat(OP_TICK,     12'h000, 1'b0, 1'b0, 24'h000000);
      send_beat(OP_STOP,     12'hFFF, 1'b1, 1'b1, 24'hFFFFFF);
      send_beat(OP_UNUSED,   12'hAAA, 1'b1, 1'b0, 24'h555555);
      send_beat(OP_MOVE,     12'hFFF, 1'b0, 1'b1, 24'hAAAAAA);
      send_beat(OP_TICK,     12'h555, 1'b1, 1'b0, 24'h123456);
      send_beat(OP_MOVE,     12'h000, 1'b0, 1'b0, 24'h000000);
      send_beat(OP_OPEN,     12'h000, 1'b0, 1'b0, 24'h000000);
      send_beat(OP_HOME,     12'h000, 1'b0, 1'b0, 24'h000000);
      send_beat(OP_TICK,     12'h000, 1'b0, 1'b1, 24'h7FFFFF);
      send_beat(OP_CLOSE,    12'h000, 1'b0, 1'b0, 24'h000000);
      send_beat(OP_TICK,     12'h000, 1'b0, 1'b1, 24'h800000);
      send_beat(OP_OPEN_ALT, 12'h000, 1'b0, 1'b0, 24'h000000);
      send_beat(OP_TICK,     12'h000, 1'b0, 1'b1, to_spos(300 * 80));
      send_beat(OP_HOME,     12'h000, 1'b0, 1'b0, 24'h000000);
      send_beat(OP_TICK,     12'h000, 1'b0, 1'b0, 24'h000000);
   endtask

   // zero settle and zero divisor; finish homing, then home from on the switch
   task automatic test_homing_and_zero_divisor();
      apply_settings(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0, 1'b1);
      send_beat(OP_TICK, 12'h000, 1'b1, 1'b0, 24'h000000);
      send_beat(OP_TICK, 12'h000, 1'b1, 1'b0, 24'h000000);
      send_beat(OP_TICK, 12'h000, 1'b0, 1'b0, 24'h000000);
      send_beat(OP_TICK, 12'h000, 1'b0, 1'b0, 24'h000000);
      send_beat(OP_TICK, 12'h000, 1'b1, 1'b0, 24'h000000);
      send_beat(OP_MOVE, 12'hFFF, 1'b0, 1'b0, 24'h000000);
      send_beat(OP_TICK, 12'h000, 1'b0, 1'b1, 24'hFFFFF9);
      send_beat(OP_HOME, 12'h000, 1'b1, 1'b0, 24'h000000);
      send_beat(OP_TICK, 12'h000, 1'b1, 1'b0, 24'h000000);
   endtask

   // several register settings, extremes among them; one phase without idling
   task automatic test_random_traffic();
      apply_settings(16'd4095, 16'd0, 16'd1, 16'd1, 16'd1, 1'b0);
      run_traffic(190);
      quiet_mode = 1'b1;
      apply_settings(16'd0, 16'd4095, 16'd255, 16'd65535, 16'd2, 1'b0);
      run_traffic(190);
      quiet_mode = 1'b0;
      apply_settings(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                     CSR_DATA_W'($urandom_range(1, 255)), CSR_DATA_W'($urandom),
                     16'd0, 1'b1);
      run_traffic(190);
      apply_settings(CSR_DATA_W'(RST_OPEN_TARGET), CSR_DATA_W'(RST_OPEN_TARGET_ALT),
                     CSR_DATA_W'(RST_STEPS_PER_UNIT), RST_SEARCH_SPEED, 16'd3, 1'b0);
      run_traffic(190);
      apply_settings(CSR_DATA_W'($urandom_range(0, 4095)), CSR_DATA_W'($urandom_range(0, 4095)),
                     CSR_DATA_W'($urandom_range(1, 16)), CSR_DATA_W'($urandom_range(1, 65535)),
                     16'd1, 1'b0);
      run_traffic(190);
   endtask

   // longest settle last: once loaded it would stall homing for the rest of the run
   task automatic test_long_settle();
      apply_settings(CSR_DATA_W'($urandom_range(0, 4095)), CSR_DATA_W'($urandom_range(0, 4095)),
                     CSR_DATA_W'($urandom_range(1, 255)), CSR_DATA_W'($urandom_range(1, 65535)),
                     16'hFFFF, 1'b0);
      run_traffic(60);
   endtask

   initial begin
      cfg_open     = RST_OPEN_TARGET;
      cfg_open_alt = RST_OPEN_TARGET_ALT;
      cfg_spu      = RST_STEPS_PER_UNIT;
      cfg_speed    = RST_SEARCH_SPEED;
      cfg_settle   = RST_SETTLE_TICKS;
      axis_now     = AX_UNKNOWN;
      home_step    = HS_START;
      position     = 0;
      door_now     = DOOR_CLOSED;
      settle_left  = '0;
      error_count  = 0;
      beats_sent   = 0;
      quiet_mode   = 1'b0;
      stall_left   = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state_and_moves();
      test_homing_and_zero_divisor();
      test_random_traffic();
      test_long_settle();

      quiesce();
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // hard stop if the run hangs
   initial begin
      #(RUN_LIMIT_NS);
      $display("CHECK FAILED");
      $finish;
   end

endmodule

### filelist.f
+incdir+src
src/ahms_pkg.sv
src/ahms_div.sv
src/ahms_useq.sv
src/axis_homing_and_move_sequencer_core.sv
test/tb_top.sv
